// ===== rtl/ulb_pkg.sv =====
`timescale 1ns / 1ps

package ulb_pkg;

  localparam int LEN_W       = 8;
  localparam int CAP_W       = 9;
  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CP_W-1:0] CP_FIRST_PRINT = 21'd32;
  localparam logic [CP_W-1:0] CP_MAX_1B      = 21'h00007F;
  localparam logic [CP_W-1:0] CP_MAX_2B      = 21'h0007FF;
  localparam logic [CP_W-1:0] CP_MAX_3B      = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;

  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_BKSP   = 2'd1,
    REQ_READ   = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_CONTROL  = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_DELETED  = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_IGNORED  = 3'd6,
    ST_READ     = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CMD_REPLY,
    CMD_APPEND,
    CMD_BKSP,
    CMD_READ
  } cmd_op_e;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    cmd_op_e         op;
    status_e         status;   // fixed answer for CMD_REPLY
    logic [3:0][7:0] enc;      // UTF-8 bytes, enc[0] stored first
    logic [2:0]      nbytes;   // 1 to 4
    logic [LEN_W-1:0] index;   // read position
  } cmd_t;

endpackage

// ===== rtl/ulb_front.sv =====
`timescale 1ns / 1ps

module ulb_front import ulb_pkg::*; (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      req_type_i,
  input  logic [CP_W-1:0] code_point_i,
  input  logic [7:0]      read_index_i,
  input  logic            enabled_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output cmd_t            q_wdata_o
);

  logic [CP_W-1:0] cp;

  assign cp         = code_point_i;
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_wdata_o        = '0;
    q_wdata_o.op     = CMD_REPLY;
    q_wdata_o.status = ST_IGNORED;
    q_wdata_o.index  = read_index_i;
    if (enabled_i) begin
      unique case (req_type_e'(req_type_i))
        REQ_APPEND: begin
          priority if (cp < CP_FIRST_PRINT) begin
            q_wdata_o.status = ST_CONTROL;
          end else if (cp > CP_MAX) begin
            q_wdata_o.status = ST_RANGE;
          end else if (cp <= CP_MAX_1B) begin
            q_wdata_o.op     = CMD_APPEND;
            q_wdata_o.enc[0] = {1'b0, cp[6:0]};
            q_wdata_o.nbytes = 3'd1;
          end else if (cp <= CP_MAX_2B) begin
            q_wdata_o.op     = CMD_APPEND;
            q_wdata_o.enc[0] = {3'b110, cp[10:6]};
            q_wdata_o.enc[1] = {CONT_TAG, cp[5:0]};
            q_wdata_o.nbytes = 3'd2;
          end else if (cp <= CP_MAX_3B) begin
            q_wdata_o.op     = CMD_APPEND;
            q_wdata_o.enc[0] = {4'b1110, cp[15:12]};
            q_wdata_o.enc[1] = {CONT_TAG, cp[11:6]};
            q_wdata_o.enc[2] = {CONT_TAG, cp[5:0]};
            q_wdata_o.nbytes = 3'd3;
          end else begin
            q_wdata_o.op     = CMD_APPEND;
            q_wdata_o.enc[0] = {5'b11110, cp[20:18]};
            q_wdata_o.enc[1] = {CONT_TAG, cp[17:12]};
            q_wdata_o.enc[2] = {CONT_TAG, cp[11:6]};
            q_wdata_o.enc[3] = {CONT_TAG, cp[5:0]};
            q_wdata_o.nbytes = 3'd4;
          end
        end
        REQ_BKSP: q_wdata_o.op = CMD_BKSP;
        REQ_READ: q_wdata_o.op = CMD_READ;
        default:  q_wdata_o.status = ST_IGNORED;
      endcase
    end
  end

endmodule

// ===== rtl/ulb_queue.sv =====
`timescale 1ns / 1ps

module ulb_queue import ulb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  localparam int QPW = $clog2(QUEUE_DEPTH);

  cmd_t             entries_q [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPW:0]     count_q, count_d;

  assign full_o  = (count_q == (QPW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/ulb_back.sv =====
`timescale 1ns / 1ps

module ulb_back import ulb_pkg::*; #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CAP_W-1:0] max_bytes_i,
  input  logic             q_empty_i,
  input  cmd_t             q_rdata_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       status_o,
  output logic [LEN_W-1:0] text_length_o,
  output logic [7:0]       read_byte_o
);

  localparam int MEM_DEPTH = (BUFFER_BYTES < 256) ? BUFFER_BYTES : 256;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MEM_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ_WAIT,
    S_SCAN_ISSUE,
    S_SCAN_CHECK
  } state_e;

  state_e           state_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] scan_idx_q;
  logic [1:0]       wcnt_q;
  logic [3:0][7:0]  enc_q;
  logic [2:0]       nbytes_q;
  logic             out_valid_q;
  status_e          status_q;
  logic [LEN_W-1:0] out_len_q;
  logic [7:0]       read_byte_q;

  logic [7:0]       text_mem [MEM_DEPTH];
  logic [7:0]       mem_rdata_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [LEN_W-1:0] wr_pos;

  logic [CAP_W-1:0] cap_eff;
  logic [CAP_W-1:0] need_len;
  logic             no_room;
  logic             last_byte;
  logic [LEN_W-1:0] grown_len;

  assign cap_eff   = (max_bytes_i < CAP_LIMIT) ? max_bytes_i : CAP_LIMIT;
  assign need_len  = {1'b0, len_q} + CAP_W'(q_rdata_i.nbytes);
  assign no_room   = (need_len >= cap_eff);
  assign last_byte = ({1'b0, wcnt_q} == (nbytes_q - 3'd1));
  assign grown_len = len_q + LEN_W'(nbytes_q);

  assign q_pop_o   = (state_q == S_IDLE) && !q_empty_i && !out_valid_q;
  assign mem_we    = (state_q == S_WRITE);
  assign wr_pos    = len_q + LEN_W'(wcnt_q);
  assign mem_waddr = wr_pos[AW-1:0];
  assign mem_raddr = (state_q == S_IDLE) ? q_rdata_i.index[AW-1:0] : scan_idx_q[AW-1:0];

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign text_length_o = out_len_q;
  assign read_byte_o   = read_byte_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= enc_q[wcnt_q];
    end
    mem_rdata_q <= text_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      scan_idx_q  <= '0;
      wcnt_q      <= '0;
      enc_q       <= '0;
      nbytes_q    <= 3'd1;
      out_valid_q <= 1'b0;
      status_q    <= ST_IGNORED;
      out_len_q   <= '0;
      read_byte_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            unique case (q_rdata_i.op)
              CMD_REPLY: begin
                out_valid_q <= 1'b1;
                status_q    <= q_rdata_i.status;
                out_len_q   <= len_q;
                read_byte_q <= '0;
              end
              CMD_APPEND: begin
                if (no_room) begin
                  out_valid_q <= 1'b1;
                  status_q    <= ST_FULL;
                  out_len_q   <= len_q;
                  read_byte_q <= '0;
                end else begin
                  enc_q    <= q_rdata_i.enc;
                  nbytes_q <= q_rdata_i.nbytes;
                  wcnt_q   <= '0;
                  state_q  <= S_WRITE;
                end
              end
              CMD_BKSP: begin
                if (len_q == '0) begin
                  out_valid_q <= 1'b1;
                  status_q    <= ST_EMPTY;
                  out_len_q   <= len_q;
                  read_byte_q <= '0;
                end else begin
                  scan_idx_q <= len_q - 1'b1;
                  state_q    <= S_SCAN_ISSUE;
                end
              end
              CMD_READ: begin
                if (q_rdata_i.index < len_q) begin
                  state_q <= S_READ_WAIT;
                end else begin
                  out_valid_q <= 1'b1;
                  status_q    <= ST_READ;
                  out_len_q   <= len_q;
                  read_byte_q <= '0;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_WRITE: begin
          wcnt_q <= wcnt_q + 1'b1;
          if (last_byte) begin
            len_q       <= grown_len;
            out_valid_q <= 1'b1;
            status_q    <= ST_APPENDED;
            out_len_q   <= grown_len;
            read_byte_q <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_READ_WAIT: begin
          out_valid_q <= 1'b1;
          status_q    <= ST_READ;
          out_len_q   <= len_q;
          read_byte_q <= mem_rdata_q;
          state_q     <= S_IDLE;
        end
        S_SCAN_ISSUE: begin
          if (scan_idx_q == '0) begin
            len_q       <= '0;
            out_valid_q <= 1'b1;
            status_q    <= ST_DELETED;
            out_len_q   <= '0;
            read_byte_q <= '0;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_SCAN_CHECK;
          end
        end
        S_SCAN_CHECK: begin
          if (mem_rdata_q[7:6] == CONT_TAG) begin
            scan_idx_q <= scan_idx_q - 1'b1;
            state_q    <= S_SCAN_ISSUE;
          end else begin
            len_q       <= scan_idx_q;
            out_valid_q <= 1'b1;
            status_q    <= ST_DELETED;
            out_len_q   <= scan_idx_q;
            read_byte_q <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The stored text never reaches the end of the memory.
  a_len_in_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, len_q} < CAP_LIMIT)
    else $error("stored length reached memory depth");

  // A pending result holds the sequencer in idle.
  a_idle_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_IDLE))
    else $error("sequencer busy while a result waits");

  // A successful append makes the text longer.
  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && (status_q == ST_APPENDED)) |-> (len_q > $past(len_q)))
    else $error("append did not grow the text");

  // A deletion makes the text shorter.
  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && (status_q == ST_DELETED)) |-> (len_q < $past(len_q)))
    else $error("deletion did not shorten the text");

endmodule

// ===== rtl/utf8_line_edit_buffer.sv =====
`timescale 1ns / 1ps
// Channel | Handshake                | Payload
// --------+--------------------------+------------------------------------------------
// in      | in_valid_i / in_ready_o  | req_type_i, code_point_i, read_index_i, enabled_i
// cfg     | cfg_valid_i / cfg_ready_o| max_bytes_i
// out     | out_valid_o / out_ready_i| status_o, text_length_o, read_byte_o
//
// Each request gives one result. A result needs no memory access for an ignored, control,
// out of range, full or empty request, or a read at or past the length; a read of a stored
// byte waits in S_READ_WAIT for memory, an append writes its bytes one by one in S_WRITE,
// and a backspace scans back in S_SCAN_ISSUE/S_SCAN_CHECK to a lead byte or position zero.
// A four-entry queue keeps taking requests until full while the back end works or its result stalls.
// Reset clears the length, queue and result register and sets max_bytes to 256, not the text.

module utf8_line_edit_buffer import ulb_pkg::*; #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [CP_W-1:0]  code_point_i,
  input  logic [7:0]       read_index_i,
  input  logic             enabled_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] max_bytes_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       status_o,
  output logic [LEN_W-1:0] text_length_o,
  output logic [7:0]       read_byte_o
);

  // Capacity register. Software must write it only while the block is idle; the block
  // itself does not enforce this, and it is always ready.
  logic [CAP_W-1:0] max_bytes_q;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= CAP_W'(256);
    end else if (cfg_valid_i) begin
      max_bytes_q <= max_bytes_i;
    end
  end

  // The front end classifies each request and encodes code points to UTF-8.
  ulb_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .code_point_i (code_point_i),
    .read_index_i (read_index_i),
    .enabled_i    (enabled_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_wdata_o    (q_wdata)
  );

  // The queue decouples request intake from execution.
  ulb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // The back end owns the text memory and the length, and holds the result.
  ulb_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_bytes_i   (max_bytes_q),
    .q_empty_i     (q_empty),
    .q_rdata_i     (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .text_length_o (text_length_o),
    .read_byte_o   (read_byte_o)
  );

endmodule
